/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL, included by the packet filter top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/pbpf_pkg.sv */
// Types and constants of the payload blocklist packet filter.
`default_nettype none
package pbpf_pkg;

  localparam int NUM_PATTERNS = 5;
  localparam int PAT_MAX      = 20;
  localparam int CNT_W        = 5;
  localparam int IDX_W        = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_DNS_ADDR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DNS_BLOCK_ENABLE = 1'd1;

  localparam logic [31:0] DNS_RESET_ADDR = 32'h0808_0808;

  typedef enum logic [1:0] {
    REASON_NONE    = 2'd0,
    REASON_EMPTY   = 2'd1,
    REASON_PATTERN = 2'd2,
    REASON_DST     = 2'd3
  } reason_t;

  localparam int PAT_LEN [NUM_PATTERNS] = '{20, 19, 15, 13, 7};

  localparam logic [7:0] PAT_BYTES [NUM_PATTERNS][PAT_MAX] = '{
    '{8'h67, 8'h6f, 8'h6f, 8'h67, 8'h6c, 8'h65, 8'h2d, 8'h61, 8'h6e, 8'h61,
      8'h6c, 8'h79, 8'h74, 8'h69, 8'h63, 8'h73, 8'h2e, 8'h63, 8'h6f, 8'h6d},
    '{8'h74, 8'h65, 8'h6c, 8'h65, 8'h6d, 8'h65, 8'h74, 8'h72, 8'h79, 8'h2e,
      8'h6d, 8'h69, 8'h63, 8'h72, 8'h6f, 8'h73, 8'h6f, 8'h66, 8'h74, 8'h00},
    '{8'h64, 8'h6f, 8'h75, 8'h62, 8'h6c, 8'h65, 8'h63, 8'h6c, 8'h69, 8'h63,
      8'h6b, 8'h2e, 8'h6e, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h61, 8'h6d, 8'h61, 8'h7a, 8'h6f, 8'h6e, 8'h61, 8'h77, 8'h73, 8'h2e,
      8'h63, 8'h6f, 8'h6d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6d, 8'h65, 8'h74, 8'h72, 8'h69, 8'h63, 8'h73, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

endpackage
`default_nettype wire

/* hw/rtl/pbpf_matcher.sv */
// Parallel compare of the byte window against the fixed patterns.
`default_nettype none
module pbpf_matcher
  import pbpf_pkg::*;
(
  input  wire logic [PAT_MAX-2:0][7:0]  window,
  input  wire logic [7:0]               cur_byte,
  input  wire logic [CNT_W-1:0]         count,
  output logic      [NUM_PATTERNS-1:0]  hit
);

  for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_pat
    logic [PAT_MAX-2:0] eq;
    logic               long_enough;

    // Window entry 0 is the byte just before the current one.
    for (genvar i = 0; i < PAT_MAX - 1; i++) begin : g_tap
      if (i < PAT_LEN[p] - 1) begin : g_cmp
        assign eq[i] = (window[i] == PAT_BYTES[p][PAT_LEN[p] - 2 - i]);
      end else begin : g_dc
        assign eq[i] = 1'b1;
      end
    end

    assign long_enough = (int'(count) >= PAT_LEN[p] - 1);
    assign hit[p] = long_enough && (&eq) && (cur_byte == PAT_BYTES[p][PAT_LEN[p] - 1]);
  end

endmodule
`default_nettype wire

/* hw/rtl/payload_blocklist_packet_filter.sv */
// A verdict word is registered in the output entry, or in the skid entry while the output entry is held.
// Throughput: one payload word per cycle while in_ready is high; the pattern compares are all combinational.
// A second result register lets input words keep flowing while one verdict waits;
// the input stalls only while two verdicts are held.
// Synchronous active-high reset clears the packet count, the hit flags and both result
// valids and loads the configuration registers; the byte window is not reset.
`default_nettype none
`include "assert_macros.svh"
module payload_blocklist_packet_filter
  import pbpf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 19
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  has_byte,
  input  wire logic                  first_of_packet,
  input  wire logic                  last_of_packet,
  input  wire logic [31:0]           dst_addr,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       verdict,
  output logic [1:0]                 drop_reason,
  output logic [IDX_W-1:0]           pattern_index
);

  logic [31:0]                    blocked_dns_addr;
  logic                           dns_block_enable;
  logic [WINDOW_DEPTH-1:0][7:0]   window;
  logic [CNT_W-1:0]               bytes_seen;
  logic [NUM_PATTERNS-1:0]        hits;

  logic                           accept;
  logic                           out_pop;
  logic                           res_push;
  logic [CNT_W-1:0]               base_cnt;
  logic [NUM_PATTERNS-1:0]        base_hits;
  logic [NUM_PATTERNS-1:0]        new_hits;
  logic [CNT_W-1:0]               bytes_seen_next;
  logic [NUM_PATTERNS-1:0]        hits_next;
  logic                           verdict_next;
  reason_t                        reason_next;
  logic [IDX_W-1:0]               index_next;

  logic                           skid_valid;
  logic                           skid_verdict;
  reason_t                        skid_reason;
  logic [IDX_W-1:0]               skid_index;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign out_pop  = out_valid && out_ready;
  assign res_push = accept && last_of_packet;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocked_dns_addr <= DNS_RESET_ADDR;
      dns_block_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCKED_DNS_ADDR: blocked_dns_addr <= cfg_wdata;
        CFG_DNS_BLOCK_ENABLE: dns_block_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // A first mark starts the packet from an empty count and no hits.
  assign base_cnt  = first_of_packet ? '0 : bytes_seen;
  assign base_hits = first_of_packet ? '0 : hits;

  pbpf_matcher u_matcher (
    .window   (window[PAT_MAX-2:0]),
    .cur_byte (data_byte),
    .count    (base_cnt),
    .hit      (new_hits)
  );

  always_comb begin
    bytes_seen_next = base_cnt;
    hits_next       = base_hits;
    if (has_byte) begin
      hits_next = base_hits | new_hits;
      if (base_cnt != {CNT_W{1'b1}}) begin
        bytes_seen_next = base_cnt + CNT_W'(1);
      end
    end
  end

  always_comb begin
    index_next = '0;
    for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
      if (hits_next[p]) begin
        index_next = IDX_W'(p);
      end
    end
    verdict_next = 1'b0;
    if (bytes_seen_next == '0) begin
      reason_next = REASON_EMPTY;
      index_next  = '0;
    end else if (|hits_next) begin
      reason_next = REASON_PATTERN;
    end else if (dns_block_enable && (dst_addr == blocked_dns_addr)) begin
      reason_next = REASON_DST;
    end else begin
      reason_next  = REASON_NONE;
      verdict_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_byte) begin
      window <= {window[WINDOW_DEPTH-2:0], data_byte};
    end
  end

  // A verdict ends the packet, so the next word starts a fresh one.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      hits       <= '0;
    end else if (accept) begin
      if (last_of_packet) begin
        bytes_seen <= '0;
        hits       <= '0;
      end else begin
        bytes_seen <= bytes_seen_next;
        hits       <= hits_next;
      end
    end
  end

  // The skid entry is only filled while the output entry is held, and it moves
  // forward as soon as the output entry is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_pop) begin
        skid_valid <= 1'b0;
      end
    end else if (res_push) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_pop) begin
        verdict       <= skid_verdict;
        drop_reason   <= skid_reason;
        pattern_index <= skid_index;
      end
    end else if (res_push) begin
      if (out_valid && !out_ready) begin
        skid_verdict <= verdict_next;
        skid_reason  <= reason_next;
        skid_index   <= index_next;
      end else begin
        verdict       <= verdict_next;
        drop_reason   <= reason_next;
        pattern_index <= index_next;
      end
    end
  end

  `ASSERT_IMPLY(a_allow_clean, clk, rst, out_valid && verdict, (drop_reason == REASON_NONE) && (pattern_index == '0))
  `ASSERT_IMPLY(a_drop_reason, clk, rst, out_valid && !verdict, drop_reason != REASON_NONE)
  `ASSERT_NEXT(a_last_gives_word, clk, rst, accept && last_of_packet, out_valid)
  `ASSERT_NEXT(a_last_clears, clk, rst, accept && last_of_packet, (bytes_seen == '0) && (hits == '0))
  `ASSERT_IMPLY(a_skid_behind_out, clk, rst, skid_valid, out_valid)

endmodule
`default_nettype wire

/* verif/pbpf_verdict_monitor.sv */
// Channel monitor for the payload filter: predicts every verdict word and compares it.
module pbpf_verdict_monitor
  import pbpf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 19
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  has_byte,
  input  logic                  first_of_packet,
  input  logic                  last_of_packet,
  input  logic [31:0]           dst_addr,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  verdict,
  input  logic [1:0]            drop_reason,
  input  logic [IDX_W-1:0]      pattern_index,
  output int                    mismatches,
  output int                    verdicts_owed,
  output int                    verdicts_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             allow;
    reason_t          reason;
    logic [IDX_W-1:0] pat;
  } verdict_t;

  logic [7:0]              recent [WINDOW_DEPTH];
  logic [CNT_W-1:0]        payload_len;
  logic [NUM_PATTERNS-1:0] hit_flags;
  logic [31:0]             blocked_addr;
  logic                    block_en;
  verdict_t                verdicts_due [$];

  initial begin
    mismatches = 0;
    verdicts_owed = 0;
    verdicts_checked = 0;
  end

  function automatic void forget_packet();
    for (int i = 0; i < WINDOW_DEPTH; i++) recent[i] = 8'h00;
    payload_len = '0;
    hit_flags = '0;
  endfunction

  // recent[0] is the byte just before b; a pattern only counts once all of it
  // lies within the bytes of the current packet.
  function automatic logic pattern_ends_at(int p, logic [7:0] b);
    int n;
    n = PAT_LEN[p];
    if (n - 1 > int'(payload_len) || n - 1 > WINDOW_DEPTH) return 1'b0;
    if (b != PAT_BYTES[p][n-1]) return 1'b0;
    for (int i = 0; i + 1 < n; i++) begin
      if (recent[i] != PAT_BYTES[p][n-2-i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void take_payload_word(logic [7:0] b, logic hb, logic first, logic last,
                                            logic [31:0] dst);
    verdict_t v;
    if (first) forget_packet();
    if (hb) begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        if (pattern_ends_at(p, b)) hit_flags[p] = 1'b1;
      end
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = b;
      if (payload_len != '1) payload_len = payload_len + 1'b1;
    end
    if (last) begin
      v.allow = 1'b1;
      v.reason = REASON_NONE;
      v.pat = '0;
      if (payload_len == '0) begin
        v.allow = 1'b0;
        v.reason = REASON_EMPTY;
      end else if (hit_flags != '0) begin
        v.allow = 1'b0;
        v.reason = REASON_PATTERN;
        for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
          if (hit_flags[p]) v.pat = IDX_W'(p);
        end
      end else if (block_en && dst == blocked_addr) begin
        v.allow = 1'b0;
        v.reason = REASON_DST;
      end
      verdicts_due.push_back(v);
      forget_packet();
    end
  endfunction

  always @(posedge clk) begin
    verdict_t want, got;
    if (rst) begin
      forget_packet();
      blocked_addr = DNS_RESET_ADDR;
      block_en = 1'b1;
      verdicts_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCKED_DNS_ADDR: blocked_addr = cfg_wdata[31:0];
          CFG_DNS_BLOCK_ENABLE: block_en = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        take_payload_word(data_byte, has_byte, first_of_packet, last_of_packet, dst_addr);
      if (out_valid && out_ready) begin
        got.allow = verdict;
        got.reason = reason_t'(drop_reason);
        got.pat = pattern_index;
        if (verdicts_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: verdict word with none predicted: verdict=%0d reason=%0d index=%0d",
                     $realtime, verdict, drop_reason, pattern_index);
        end else begin
          want = verdicts_due.pop_front();
          verdicts_checked++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: verdict mismatch: expected verdict=%0d reason=%0d index=%0d,",
                       $realtime, want.allow, want.reason, want.pat,
                       " got verdict=%0d reason=%0d index=%0d",
                       verdict, drop_reason, pattern_index);
          end
        end
      end
    end
    verdicts_owed <= verdicts_due.size();
  end

endmodule

/* verif/tb_payload_blocklist_packet_filter.sv */
// Top of the payload filter testbench: clock, reset, stimulus and the final verdict.
module tb_payload_blocklist_packet_filter
  import pbpf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW = 19;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BLOCKED_DNS_ADDR;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            data_byte = 8'h00;
  logic                  has_byte = 1'b0;
  logic                  first_of_packet = 1'b0;
  logic                  last_of_packet = 1'b0;
  logic [31:0]           dst_addr = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  verdict;
  logic [1:0]            drop_reason;
  logic [IDX_W-1:0]      pattern_index;

  int mismatches, verdicts_owed, verdicts_checked;
  int gap_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;
  int packets_sent = 0;
  logic [31:0] cur_addr = DNS_RESET_ADDR;

  payload_blocklist_packet_filter #(.WINDOW_DEPTH(WINDOW)) dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .data_byte, .has_byte, .first_of_packet, .last_of_packet, .dst_addr,
    .out_valid, .out_ready, .verdict, .drop_reason, .pattern_index
  );

  pbpf_verdict_monitor #(.WINDOW_DEPTH(WINDOW)) monitor (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .data_byte, .has_byte, .first_of_packet, .last_of_packet, .dst_addr,
    .out_valid, .out_ready, .verdict, .drop_reason, .pattern_index,
    .mismatches, .verdicts_owed, .verdicts_checked
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_word(input logic [7:0] b, input logic hb, input logic first,
                           input logic last, input logic [31:0] dst);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    has_byte <= hb;
    first_of_packet <= first;
    last_of_packet <= last;
    dst_addr <= dst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (last) packets_sent++;
  endtask

  // Valid is dropped first, since the last word may have just been accepted.
  task automatic drain_verdicts(input int hold);
    in_valid <= 1'b0;
    do @(posedge clk); while (verdicts_owed != 0);
    repeat (hold) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_packet();
    logic [7:0] body [$];
    int nseg, p, n, k, len;
    logic [31:0] dst;
    logic [7:0] b;
    bit mark_first, blank_tail, fin;
    nseg = ($urandom_range(14) == 0) ? 0 : $urandom_range(1, 3);
    for (int s = 0; s < nseg; s++) begin
      p = $urandom_range(NUM_PATTERNS - 1);
      n = PAT_LEN[p];
      case ($urandom_range(11))
        0, 1, 2, 3, 4: for (int i = 0; i < n; i++) body.push_back(PAT_BYTES[p][i]);
        5: begin
          len = $urandom_range(1, n - 1);
          for (int i = 0; i < len; i++) body.push_back(PAT_BYTES[p][i]);
        end
        6: for (int i = $urandom_range(1, n - 1); i < n; i++) body.push_back(PAT_BYTES[p][i]);
        7: begin
          // One flipped bit must spoil the match.
          k = $urandom_range(n - 1);
          for (int i = 0; i < n; i++) begin
            b = PAT_BYTES[p][i];
            if (i == k) b[$urandom_range(7)] ^= 1'b1;
            body.push_back(b);
          end
        end
        8, 9: begin
          len = $urandom_range(1, 12);
          for (int i = 0; i < len; i++) begin
            k = $urandom_range(NUM_PATTERNS - 1);
            body.push_back(PAT_BYTES[k][$urandom_range(PAT_LEN[k] - 1)]);
          end
        end
        10: begin
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++) body.push_back(8'($urandom));
        end
        default: begin
          // Up to 45 bytes, which can saturate the byte count at 31.
          len = $urandom_range(20, 45);
          for (int i = 0; i < len; i++) body.push_back(8'($urandom));
        end
      endcase
    end
    case ($urandom_range(9))
      0, 1, 2, 3: dst = cur_addr;
      4, 5: dst = cur_addr ^ (32'h1 << $urandom_range(31));
      default: dst = $urandom;
    endcase
    mark_first = ($urandom_range(99) < 85);
    if (body.size() == 0) begin
      send_word(8'($urandom), 1'b0, mark_first, 1'b1, dst);
      return;
    end
    blank_tail = ($urandom_range(9) == 0);
    for (int i = 0; i < body.size(); i++) begin
      if ($urandom_range(19) == 0) begin
        send_word(8'($urandom), 1'b0, mark_first, 1'b0, $urandom);
        mark_first = 1'b0;
      end
      fin = (i == body.size() - 1) && !blank_tail;
      send_word(body[i], 1'b1, mark_first || (i > 0 && $urandom_range(49) == 0), fin,
                fin ? dst : $urandom);
      mark_first = 1'b0;
    end
    if (blank_tail) send_word(8'($urandom), 1'b0, 1'b0, 1'b1, dst);
  endtask

  initial begin
    logic [31:0] addr_setting [4];
    logic [31:0] en_setting [4];
    int chunk_start;
    addr_setting = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'hFFFF_FFFF};
    // Only bit 0 of the enable counts; the upper bits are set on purpose.
    en_setting = '{32'h0000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h8000_0001};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gap_pct = 10;
    stall_pct = 75;

    // Directed part under the reset register values.
    send_word(8'h00, 1'b0, 1'b1, 1'b1, DNS_RESET_ADDR);
    send_word(8'hFF, 1'b1, 1'b1, 1'b1, DNS_RESET_ADDR);
    send_word(8'h00, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    for (int i = 0; i < PAT_LEN[4]; i++)
      send_word(PAT_BYTES[4][i], 1'b1, i == 0, i == PAT_LEN[4] - 1, DNS_RESET_ADDR);
    // No first mark, and a word without a byte in the middle of the pattern.
    for (int i = 0; i < PAT_LEN[4]; i++) begin
      if (i == 3) send_word(8'hAA, 1'b0, 1'b0, 1'b0, 32'h0);
      send_word(PAT_BYTES[4][i], 1'b1, 1'b0, i == PAT_LEN[4] - 1, 32'h0);
    end
    send_word(8'h55, 1'b0, 1'b0, 1'b1, 32'h0);
    send_word(8'h01, 1'b1, 1'b0, 1'b0, 32'h0);
    send_word(8'hFE, 1'b0, 1'b0, 1'b1, 32'h0);

    for (int s = 0; s < 4; s++) begin
      drain_verdicts(3);
      write_reg(CFG_BLOCKED_DNS_ADDR, addr_setting[s]);
      write_reg(CFG_DNS_BLOCK_ENABLE, en_setting[s]);
      cur_addr = addr_setting[s];
      case (s)
        0: begin gap_pct = 10; stall_pct = 75; end
        1: begin gap_pct = 75; stall_pct = 10; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      chunk_start = words_sent;
      while (words_sent - chunk_start < 375) begin
        if ($urandom_range(29) == 0) drain_verdicts(0);
        send_random_packet();
      end
    end
    drain_verdicts(4);

    $display("Checked %0d verdict words from %0d packets (%0d payload words) over four",
             verdicts_checked, packets_sent, words_sent);
    $display("register settings and three idling patterns; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timed out with %0d verdict words still owed.", verdicts_owed);
    $display("== FAIL ==");
    $finish;
  end

endmodule
